>>> hw/rtl/msild_pkg.sv
// Shared types, constants and helper function of the mid/side level-balance block.
package msild_pkg;

	localparam int GAIN_ONE   = 65536;   // unity gain in Q1.16
	localparam int ROT_COEF   = 46341;   // 0.7071 in Q0.16
	localparam int ENERGY_W   = 64;      // saturating energy accumulators
	localparam int DIVW       = 64;      // divider working width
	localparam int QUOT_W     = 17;      // quotient bits per division
	localparam int SQRT_STEPS = 32;      // one result bit per step of a 64-bit root
	localparam int FLUSH_WAIT = 2;       // energy pipeline depth after the last load
	localparam int STEP_W     = 6;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef enum logic [6:0] {
		ST_LOAD     = 7'b0000001,
		ST_FLUSH    = 7'b0000010,
		ST_SQRT_L   = 7'b0000100,
		ST_SQRT_R   = 7'b0001000,
		ST_DIV_ILD  = 7'b0010000,
		ST_DIV_GAIN = 7'b0100000,
		ST_DRAIN    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic new_frame;
		logic drain;
		logic sqrt_init;
		logic sqrt_sel;
		logic sqrt_step;
		logic ild_init;
		logic div_step;
		logic gain_init;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic full_cont;
		logic len_one;
		logic drain_last;
		logic busy;
	} status_t;

	// floor(sqrt(2^(2*sw-1))), the output saturation limit
	function automatic logic [63:0] out_limit(input int sw);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bit_v;
		v     = 64'd1 << (2 * sw - 1);
		res   = 64'd0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + bit_v) begin
				v   = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/msild_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msild_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/msild_ctrl.sv
// Controller state machine: load, per-frame root and division sequence, drain.
module msild_ctrl import msild_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    kind,
	input  status_t status,
	output logic    in_ready,
	output cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              acc;

	assign in_ready = !status.busy && (state_q == ST_LOAD || state_q == ST_DRAIN);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (acc && kind == KIND_LOAD) begin
					cmd.load = 1'b1;
					if (status.full_cont) begin
						state_d = ST_FLUSH;
						cnt_d   = STEP_W'(FLUSH_WAIT);
					end
				end
			end
			ST_FLUSH: begin
				if (cnt_q == '0) begin
					cmd.sqrt_init = 1'b1;
					state_d       = ST_SQRT_L;
					cnt_d         = STEP_W'(SQRT_STEPS);
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_SQRT_L: begin
				if (cnt_q != '0) begin
					cmd.sqrt_step = 1'b1;
					cnt_d         = cnt_q - 1'b1;
				end else begin
					cmd.sqrt_init = 1'b1;
					cmd.sqrt_sel  = 1'b1;
					state_d       = ST_SQRT_R;
					cnt_d         = STEP_W'(SQRT_STEPS);
				end
			end
			ST_SQRT_R: begin
				if (cnt_q != '0) begin
					cmd.sqrt_step = 1'b1;
					cnt_d         = cnt_q - 1'b1;
				end else begin
					cmd.ild_init = 1'b1;
					state_d      = ST_DIV_ILD;
					cnt_d        = STEP_W'(QUOT_W);
				end
			end
			ST_DIV_ILD: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 1'b1;
				end else begin
					cmd.gain_init = 1'b1;
					state_d       = ST_DIV_GAIN;
					cnt_d         = STEP_W'(QUOT_W);
				end
			end
			ST_DIV_GAIN: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (acc && kind == KIND_LOAD) begin
					// a sample abandons the rest of the frame
					cmd.load      = 1'b1;
					cmd.new_frame = 1'b1;
					if (status.len_one) begin
						state_d = ST_FLUSH;
						cnt_d   = STEP_W'(FLUSH_WAIT);
					end else begin
						state_d = ST_LOAD;
					end
				end else if (acc) begin
					cmd.drain = 1'b1;
					if (status.drain_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

>>> hw/rtl/msild_dpath.sv
// Datapath: sample stores, energy sums, root and divider units, drain pipeline.
module msild_dpath import msild_pkg::*; #(
	parameter int FRAME_MAX     = 1024,
	parameter int SAMPLE_WIDTH  = 24,
	parameter int BALANCE_RANGE = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [$clog2(FRAME_MAX):0]       frame_length,
	input  logic signed [SAMPLE_WIDTH-1:0]   left_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]   right_sample,
	input  cmd_t                             cmd,
	output status_t                          status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [SAMPLE_WIDTH:0]     mid_sample,
	output logic signed [SAMPLE_WIDTH:0]     side_sample,
	output logic [$clog2(BALANCE_RANGE)-1:0] level_index,
	output logic [$clog2(FRAME_MAX)-1:0]     position,
	output logic                             last_of_frame
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = $clog2(FRAME_MAX);
	localparam int CW = AW + 1;
	localparam int LW = $clog2(BALANCE_RANGE);
	localparam int PW = SW + 18;
	localparam int MW = SW + 17;
	localparam int RW = MW + 16;
	localparam logic [SW:0] LIMIT = (SW + 1)'(out_limit(SAMPLE_WIDTH));

	// configuration and counters
	logic [CW-1:0] frame_len_q, eff_len, load_cnt_q, drain_cnt_q, load_base;
	logic [AW-1:0] wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= CW'(FRAME_MAX);
		end else if (cfg_valid) begin
			frame_len_q <= frame_length;
		end
	end

	always_comb begin
		if (frame_len_q == '0) begin
			eff_len = CW'(1);
		end else if (frame_len_q > CW'(FRAME_MAX)) begin
			eff_len = CW'(FRAME_MAX);
		end else begin
			eff_len = frame_len_q;
		end
	end

	assign load_base         = cmd.new_frame ? '0 : load_cnt_q;
	assign wr_addr           = load_base[AW-1:0];
	assign status.full_cont  = ({1'b0, load_cnt_q} + 1'b1) >= {1'b0, eff_len};
	assign status.len_one    = eff_len == CW'(1);
	assign status.drain_last = ({1'b0, drain_cnt_q} + 1'b1) >= {1'b0, load_cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			drain_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				load_cnt_q <= load_base + 1'b1;
				if (cmd.new_frame) begin
					drain_cnt_q <= '0;
				end
			end
			if (cmd.drain) begin
				if (status.drain_last) begin
					load_cnt_q  <= '0;
					drain_cnt_q <= '0;
				end else begin
					drain_cnt_q <= drain_cnt_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				drain_cnt_q <= '0;
			end
		end
	end

	// sample stores
	logic [SW-1:0] l_rd, r_rd;

	msild_ram #(.WIDTH(SW), .DEPTH(FRAME_MAX)) u_left_ram (
		.clk     (clk),
		.wr_en   (cmd.load),
		.wr_addr (wr_addr),
		.wr_data (left_sample),
		.rd_en   (cmd.drain),
		.rd_addr (drain_cnt_q[AW-1:0]),
		.rd_data (l_rd)
	);

	msild_ram #(.WIDTH(SW), .DEPTH(FRAME_MAX)) u_right_ram (
		.clk     (clk),
		.wr_en   (cmd.load),
		.wr_addr (wr_addr),
		.wr_data (right_sample),
		.rd_en   (cmd.drain),
		.rd_addr (drain_cnt_q[AW-1:0]),
		.rd_data (r_rd)
	);

	// energy accumulation: register, square, saturating add
	logic                   ld_v_s1, sq_v_s2;
	logic signed [SW-1:0]   l_s1, r_s1;
	logic [2*SW-1:0]        lsq_s2, rsq_s2;
	logic [ENERGY_W-1:0]    l_energy_q, r_energy_q;
	logic [ENERGY_W:0]      l_sum, r_sum;

	assign l_sum = {1'b0, l_energy_q} + (ENERGY_W + 1)'(lsq_s2);
	assign r_sum = {1'b0, r_energy_q} + (ENERGY_W + 1)'(rsq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1    <= 1'b0;
			sq_v_s2    <= 1'b0;
			l_energy_q <= '0;
			r_energy_q <= '0;
		end else begin
			ld_v_s1 <= cmd.load;
			sq_v_s2 <= ld_v_s1;
			if (cmd.finish) begin
				l_energy_q <= '0;
				r_energy_q <= '0;
			end else if (sq_v_s2) begin
				l_energy_q <= l_sum[ENERGY_W] ? '1 : l_sum[ENERGY_W-1:0];
				r_energy_q <= r_sum[ENERGY_W] ? '1 : r_sum[ENERGY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_s1 <= left_sample;
			r_s1 <= right_sample;
		end
		lsq_s2 <= (2 * SW)'(l_s1 * l_s1);
		rsq_s2 <= (2 * SW)'(r_s1 * r_s1);
	end

	// shared square root unit, one result bit per step
	logic [ENERGY_W-1:0] rt_v_q, rt_res_q, rt_bit_q, rt_trial;
	logic [31:0]         n0_q;

	assign rt_trial = rt_res_q | rt_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rt_v_q   <= cmd.sqrt_sel ? r_energy_q : l_energy_q;
			rt_res_q <= '0;
			rt_bit_q <= ENERGY_W'(1) << (ENERGY_W - 2);
			if (cmd.sqrt_sel) begin
				n0_q <= rt_res_q[31:0];
			end
		end else if (cmd.sqrt_step) begin
			if (rt_v_q >= rt_trial) begin
				rt_v_q   <= rt_v_q - rt_trial;
				rt_res_q <= (rt_res_q >> 1) | rt_bit_q;
			end else begin
				rt_res_q <= rt_res_q >> 1;
			end
			rt_bit_q <= rt_bit_q >> 2;
		end
	end

	// shared restoring divider and level quantizer
	logic [DIVW-1:0]   div_n_q, div_d_q;
	logic [QUOT_W-1:0] div_q_q;
	logic [32:0]       tot;
	logic              tot_zero_q, scale_r_q, equal_q;
	logic [LW-1:0]     ild_c, ild_q, num_c;

	assign tot = {1'b0, n0_q} + {1'b0, rt_res_q[31:0]};

	always_comb begin
		if (tot_zero_q || div_q_q < QUOT_W'(1)) begin
			ild_c = LW'(1);
		end else if (div_q_q > QUOT_W'(BALANCE_RANGE - 1)) begin
			ild_c = LW'(BALANCE_RANGE - 1);
		end else begin
			ild_c = div_q_q[LW-1:0];
		end
		num_c = LW'(BALANCE_RANGE - int'(ild_c));
	end

	always_ff @(posedge clk) begin
		if (cmd.ild_init) begin
			tot_zero_q <= tot == '0;
			div_n_q    <= DIVW'(n0_q) * DIVW'(2 * BALANCE_RANGE) + DIVW'(tot);
			div_d_q    <= DIVW'(tot) << QUOT_W;
			div_q_q    <= '0;
		end else if (cmd.gain_init) begin
			ild_q   <= ild_c;
			div_q_q <= '0;
			if (num_c > ild_c) begin
				scale_r_q <= 1'b1;
				equal_q   <= 1'b0;
				div_n_q   <= (DIVW'(ild_c) << QUOT_W) + DIVW'(num_c);
				div_d_q   <= DIVW'(num_c) << QUOT_W;
			end else if (num_c < ild_c) begin
				scale_r_q <= 1'b0;
				equal_q   <= 1'b0;
				div_n_q   <= (DIVW'(num_c) << QUOT_W) + DIVW'(ild_c);
				div_d_q   <= DIVW'(ild_c) << QUOT_W;
			end else begin
				scale_r_q <= 1'b0;
				equal_q   <= 1'b1;
			end
		end else if (cmd.div_step) begin
			if (div_n_q >= div_d_q) begin
				div_n_q <= div_n_q - div_d_q;
				div_q_q <= {div_q_q[QUOT_W-2:0], 1'b1};
			end else begin
				div_q_q <= {div_q_q[QUOT_W-2:0], 1'b0};
			end
			div_d_q <= div_d_q >> 1;
		end
	end

	// frame results
	logic [LW-1:0]     level_q;
	logic [QUOT_W-1:0] gain_q;
	logic              scale_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= LW'(1);
			gain_q        <= QUOT_W'(GAIN_ONE);
			scale_right_q <= 1'b0;
		end else if (cmd.finish) begin
			level_q       <= ild_q;
			gain_q        <= equal_q ? QUOT_W'(GAIN_ONE) : div_q_q;
			scale_right_q <= scale_r_q;
		end
	end

	// drain pipeline: read, gain, sum/difference, magnitude, rotate, round
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, adv6, hold4;
	logic [AW-1:0]       pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic                last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [QUOT_W-1:0]   gl, gr;
	logic signed [PW-1:0] lp_s2, rp_s2;
	logic signed [PW:0]  sum_s3, dif_s3;
	logic                msign_s4, ssign_s4, msign_s5, ssign_s5, msign_s6, ssign_s6;
	logic [MW-1:0]       mmag_s4, smag_s4;
	logic [RW-1:0]       mprod_s5, sprod_s5, mround, sround;
	logic [SW:0]         mq_s6, sq_s6, msat, ssat;

	assign gl     = scale_right_q ? QUOT_W'(GAIN_ONE) : gain_q;
	assign gr     = scale_right_q ? gain_q : QUOT_W'(GAIN_ONE);
	assign adv6   = !out_valid || out_ready;
	// park the item at stage four while the output register is still full
	assign hold4  = v_s4 && !adv6;
	assign mround = mprod_s5 + (RW'(1) << 31);
	assign sround = sprod_s5 + (RW'(1) << 31);
	assign msat   = (mq_s6 > LIMIT) ? LIMIT : mq_s6;
	assign ssat   = (sq_s6 > LIMIT) ? LIMIT : sq_s6;
	assign status.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= cmd.drain;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (!hold4) begin
				v_s4 <= v_s3;
			end
			if (adv6) begin
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
			if (v_s6 && adv6) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			pos_s1  <= drain_cnt_q[AW-1:0];
			last_s1 <= status.drain_last;
		end
		pos_s2   <= pos_s1;
		last_s2  <= last_s1;
		lp_s2    <= PW'($signed(l_rd) * $signed({1'b0, gl}));
		rp_s2    <= PW'($signed(r_rd) * $signed({1'b0, gr}));
		pos_s3   <= pos_s2;
		last_s3  <= last_s2;
		sum_s3   <= (PW + 1)'(lp_s2) + (PW + 1)'(rp_s2);
		dif_s3   <= (PW + 1)'(lp_s2) - (PW + 1)'(rp_s2);
		if (!hold4) begin
			pos_s4   <= pos_s3;
			last_s4  <= last_s3;
			msign_s4 <= sum_s3[PW];
			ssign_s4 <= dif_s3[PW];
			mmag_s4  <= MW'(sum_s3[PW] ? -sum_s3 : sum_s3);
			smag_s4  <= MW'(dif_s3[PW] ? -dif_s3 : dif_s3);
		end
		if (adv6) begin
			pos_s5   <= pos_s4;
			last_s5  <= last_s4;
			msign_s5 <= msign_s4;
			ssign_s5 <= ssign_s4;
			mprod_s5 <= RW'(mmag_s4) * RW'(ROT_COEF);
			sprod_s5 <= RW'(smag_s4) * RW'(ROT_COEF);
			pos_s6   <= pos_s5;
			last_s6  <= last_s5;
			msign_s6 <= msign_s5;
			ssign_s6 <= ssign_s5;
			mq_s6    <= mround[RW-1:32];
			sq_s6    <= sround[RW-1:32];
		end
		if (v_s6 && adv6) begin
			mid_sample    <= msign_s6 ? -$signed(msat) : $signed(msat);
			side_sample   <= ssign_s6 ? -$signed(ssat) : $signed(ssat);
			level_index   <= level_q;
			position      <= pos_s6;
			last_of_frame <= last_s6;
		end
	end

endmodule

>>> hw/rtl/stereo_mid_side_with_ild.sv
// Top level of the mid/side stereo rotation with interchannel level balance.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | in        | in_valid / in_ready   | kind, left_sample, right_sample
//  out     | out       | out_valid / out_ready | mid_sample, side_sample, level_index,
//          |           |                       | position, last_of_frame
//  cfg     | in        | cfg_valid / cfg_ready | frame_length
//
// Load items are taken one per cycle while the drain pipeline is empty. The item that
// completes a frame is followed by per-frame work (energy flush, two square roots in
// the shared root unit, level and gain divisions), during which in_ready is low.
// Each drain item then occupies the six-stage drain pipeline, and the next item is
// taken only once it has left; the output register lets the result wait while the next
// item enters. A stalled output parks that next item at the fourth stage. Reset is
// asynchronous, active low, and leaves the block loading a fresh frame; the stores
// need no clear.
module stereo_mid_side_with_ild import msild_pkg::*; #(
	parameter int FRAME_MAX     = 1024,
	parameter int SAMPLE_WIDTH  = 24,
	parameter int BALANCE_RANGE = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [$clog2(FRAME_MAX):0]       frame_length,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic signed [SAMPLE_WIDTH-1:0]   left_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]   right_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_WIDTH:0]     mid_sample,
	output logic signed [SAMPLE_WIDTH:0]     side_sample,
	output logic [$clog2(BALANCE_RANGE)-1:0] level_index,
	output logic [$clog2(FRAME_MAX)-1:0]     position,
	output logic                             last_of_frame
);

	cmd_t    cmd;
	status_t status;

	// frame length is taken in any cycle; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	// sequence loads, per-frame arithmetic and drains
	msild_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// hold samples, accumulate energy, compute balance and rotate on drain
	msild_dpath #(
		.FRAME_MAX     (FRAME_MAX),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.BALANCE_RANGE (BALANCE_RANGE)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.frame_length  (frame_length),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.mid_sample    (mid_sample),
		.side_sample   (side_sample),
		.level_index   (level_index),
		.position      (position),
		.last_of_frame (last_of_frame)
	);

endmodule

>>> hw/rtl/msild_check.sv
// Port-level checker for the mid/side level-balance block, with its bind.
module msild_check import msild_pkg::*; #(
	parameter int FRAME_MAX     = 1024,
	parameter int SAMPLE_WIDTH  = 24,
	parameter int BALANCE_RANGE = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [$clog2(FRAME_MAX):0]       frame_length,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             kind,
	input logic signed [SAMPLE_WIDTH-1:0]   left_sample,
	input logic signed [SAMPLE_WIDTH-1:0]   right_sample,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [SAMPLE_WIDTH:0]     mid_sample,
	input logic signed [SAMPLE_WIDTH:0]     side_sample,
	input logic [$clog2(BALANCE_RANGE)-1:0] level_index,
	input logic [$clog2(FRAME_MAX)-1:0]     position,
	input logic                             last_of_frame
);

	localparam logic signed [SAMPLE_WIDTH:0] LIM_P = (SAMPLE_WIDTH + 1)'(out_limit(SAMPLE_WIDTH));
	localparam logic signed [SAMPLE_WIDTH:0] LIM_N = -LIM_P;
	localparam int LW = $clog2(BALANCE_RANGE);

	// a stalled result keeps its samples, position and last flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mid_sample) && $stable(side_sample)
			&& $stable(position) && $stable(last_of_frame))
		else $error("stalled result changed");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_index != '0 && level_index <= LW'(BALANCE_RANGE - 1))
		else $error("level index out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mid_sample <= LIM_P && mid_sample >= LIM_N
			&& side_sample <= LIM_P && side_sample >= LIM_N)
		else $error("rotated sample beyond saturation limit");

	// a new result never lands in the same cycle an item is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared while an item was being accepted");

endmodule

bind stereo_mid_side_with_ild msild_check #(
	.FRAME_MAX     (FRAME_MAX),
	.SAMPLE_WIDTH  (SAMPLE_WIDTH),
	.BALANCE_RANGE (BALANCE_RANGE)
) u_msild_check (.*);

>>> tb/sv/testbench.sv
// Testbench for the mid/side stereo rotation with interchannel level balance.
module testbench;
	import msild_pkg::*;

	localparam int RANGE   = 32;
	localparam int FMAX    = 1024;
	localparam int LIMIT   = 3000000;
	localparam int SETTLE  = 200;     // covers the per-frame work and the drain pipe

	typedef enum logic [0:0] {PH_FILL, PH_EMPTY} phase_t;

	typedef struct {
		logic signed [24:0] mid;
		logic signed [24:0] side;
		logic [4:0]         lvl;
		logic [9:0]         pos;
		logic               last;
	} pair_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [10:0] frame_length;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic signed [23:0] left_sample;
	logic signed [23:0] right_sample;
	logic out_valid;
	logic out_ready;
	logic signed [24:0] mid_sample;
	logic signed [24:0] side_sample;
	logic [4:0] level_index;
	logic [9:0] position;
	logic last_of_frame;

	stereo_mid_side_with_ild u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .frame_length(frame_length),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .left_sample(left_sample), .right_sample(right_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.mid_sample(mid_sample), .side_sample(side_sample), .level_index(level_index),
		.position(position), .last_of_frame(last_of_frame)
	);

	// Predictor state: a shadow copy of the block's frame stores and per-frame results.
	int                 pl_left [FMAX];
	int                 pl_right [FMAX];
	longint unsigned    nrg_left, nrg_right;
	int unsigned        n_loaded, n_drained;
	phase_t             pl_phase;
	int unsigned        pl_level, pl_gain;
	bit                 pl_scale_right;
	int unsigned        pl_len;
	longint unsigned    sat_mag;

	pair_t  pending_pairs[$];
	bit     failed;
	bit     calm;           // when set, neither side idles
	int     n_sent;
	longint cycles;

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned add_sat(input longint unsigned a, input longint unsigned b);
		return (a + b < a) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
	endfunction

	function automatic longint unsigned square_of(input int x);
		longint unsigned m;
		m = (x < 0) ? longint'(-longint'(x)) : longint'(x);
		return m * m;
	endfunction

	// Multiply a Q.16 sum by 0.7071, round half away from zero, saturate.
	function automatic logic signed [24:0] rotate_q16(input longint sum);
		bit              neg;
		longint unsigned mag, q;
		neg = sum < 0;
		mag = neg ? -sum : sum;
		q   = (mag * 64'd46341 + (64'd1 << 31)) >> 32;
		if (q > sat_mag) q = sat_mag;
		return neg ? -$signed(25'(q)) : $signed(25'(q));
	endfunction

	function automatic int unsigned active_len();
		if (pl_len == 0) return 1;
		if (pl_len > FMAX) return FMAX;
		return pl_len;
	endfunction

	// Derive the level index and balance gain once a frame is loaded.
	task automatic close_frame();
		longint unsigned n0, n1, tot, q;
		int unsigned     num;
		n0  = root64(nrg_left);
		n1  = root64(nrg_right);
		tot = n0 + n1;
		pl_level = 1;
		if (tot != 0) begin
			q = (2 * RANGE * n0 + tot) / (2 * tot);
			if (q < 1) q = 1;
			if (q > RANGE - 1) q = RANGE - 1;
			pl_level = 32'(q);
		end
		num = RANGE - pl_level;
		pl_scale_right = 0;
		pl_gain = GAIN_ONE;
		if (num > pl_level) begin
			pl_scale_right = 1;
			pl_gain = 32'((2 * 64'(GAIN_ONE) * pl_level + num) / (2 * 64'(num)));
		end else if (num < pl_level) begin
			pl_gain = 32'((2 * 64'(GAIN_ONE) * num + pl_level) / (2 * 64'(pl_level)));
		end
		nrg_left  = 0;
		nrg_right = 0;
		n_drained = 0;
		pl_phase  = PH_EMPTY;
	endtask

	// Advance the shadow state by one accepted item; queue any pair it yields.
	task automatic predict_item(input logic k, input logic signed [23:0] l,
			input logic signed [23:0] r);
		pair_t  p;
		longint sl, sr;
		int     idx;
		if (k == KIND_LOAD) begin
			if (pl_phase != PH_FILL) begin
				pl_phase  = PH_FILL;
				n_loaded  = 0;
				n_drained = 0;
				nrg_left  = 0;
				nrg_right = 0;
			end
			if (n_loaded < FMAX) begin
				pl_left[n_loaded]  = int'(l);
				pl_right[n_loaded] = int'(r);
				n_loaded++;
			end
			nrg_left  = add_sat(nrg_left, square_of(int'(l)));
			nrg_right = add_sat(nrg_right, square_of(int'(r)));
			if (n_loaded >= active_len()) close_frame();
			return;
		end
		if (pl_phase != PH_EMPTY) return;
		idx = (n_drained < FMAX) ? n_drained : 0;
		sl  = longint'(pl_left[idx]) * (pl_scale_right ? GAIN_ONE : pl_gain);
		sr  = longint'(pl_right[idx]) * (pl_scale_right ? pl_gain : GAIN_ONE);
		p.mid  = rotate_q16(sl + sr);
		p.side = rotate_q16(sl - sr);
		p.lvl  = pl_level[4:0];
		p.pos  = n_drained[9:0];
		p.last = (n_drained + 1) >= n_loaded;
		pending_pairs.push_back(p);
		n_drained++;
		if (p.last) begin
			pl_phase  = PH_FILL;
			n_loaded  = 0;
			n_drained = 0;
		end
	endtask

	// Clock, cycle limit
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Output side: draw a stall per result, compare each accepted pair at the falling
	// edge, where every output has settled.
	int  out_wait;
	bit  out_took;

	always @(posedge clk) begin
		if (out_took) begin
			out_wait = calm ? 0 : $urandom_range(0, 13);
			out_took = 0;
		end
		out_ready <= (out_wait == 0);
		if (out_wait > 0) out_wait--;
	end

	always @(negedge clk) begin
		pair_t e;
		if (arst_n && out_valid && out_ready) begin
			out_took = 1;
			if (pending_pairs.size() == 0) begin
				$display("%0t: unexpected pair mid=%0d side=%0d", $time, mid_sample,
					side_sample);
				failed = 1;
			end else begin
				e = pending_pairs.pop_front();
				if (mid_sample !== e.mid) begin
					$display("%0t: mid exp %0d got %0d", $time, e.mid, mid_sample);
					failed = 1;
				end
				if (side_sample !== e.side) begin
					$display("%0t: side exp %0d got %0d", $time, e.side, side_sample);
					failed = 1;
				end
				if (level_index !== e.lvl) begin
					$display("%0t: level exp %0d got %0d", $time, e.lvl, level_index);
					failed = 1;
				end
				if (position !== e.pos) begin
					$display("%0t: position exp %0d got %0d", $time, e.pos, position);
					failed = 1;
				end
				if (last_of_frame !== e.last) begin
					$display("%0t: last exp %0b got %0b", $time, e.last, last_of_frame);
					failed = 1;
				end
			end
		end
	end

	// Send one item: idle a random gap, raise valid, hold until accepted.
	task automatic send_item(input logic k, input logic signed [23:0] l,
			input logic signed [23:0] r);
		int gap;
		bit took;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1;
		kind         <= k;
		left_sample  <= l;
		right_sample <= r;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predict_item(k, l, r);
		n_sent++;
	endtask

	// Hold the input quiet until every queued pair is out, then let the block settle.
	task automatic drain_wait();
		in_valid <= 0;
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the frame length; only ever called after reset or drain_wait.
	task automatic write_length(input int unsigned v);
		bit took;
		cfg_valid    <= 1;
		frame_length <= v[10:0];
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 0;
		pl_len = v & 11'h7FF;
	endtask

	function automatic logic signed [23:0] pick_sample(input int sh);
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'sd0;
			default: return $signed(24'($urandom)) >>> sh;
		endcase
	endfunction

	task automatic drain_frame(input int n);
		repeat (n) send_item(KIND_DRAIN, 0, 0);
	endtask

	// Extremes of the sample range, silent frame, balanced frame, ignored drain,
	// and a load that cuts a drain short.
	task automatic test_directed();
		write_length(1);
		send_item(KIND_DRAIN, 0, 0);
		send_item(KIND_LOAD, 24'sh7FFFFF, 24'sh800000);
		drain_frame(1);
		send_item(KIND_LOAD, 24'sh800000, 24'sh7FFFFF);
		drain_frame(1);
		send_item(KIND_LOAD, 0, 0);
		drain_frame(1);
		send_item(KIND_LOAD, 1234567, 1234567);
		drain_frame(1);
		send_item(KIND_LOAD, 24'sh7FFFFF, 0);
		drain_frame(1);
		drain_wait();
		write_length(3);
		send_item(KIND_LOAD, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(KIND_LOAD, 24'sh800000, 24'sh800000);
		send_item(KIND_LOAD, -1, 1);
		drain_frame(1);
		send_item(KIND_LOAD, 5, -7);
		send_item(KIND_LOAD, 24'sh800000, 24'sh7FFFFF);
		send_item(KIND_LOAD, 24'sh7FFFFF, 24'sh800000);
		drain_frame(3);
		drain_wait();
	endtask

	// Zero acts as one; a single-pair frame with no idling.
	task automatic test_length_limits();
		write_length(0);
		send_item(KIND_LOAD, 99, -99);
		drain_frame(1);
		drain_wait();
		calm = 1;
		write_length(1);
		send_item(KIND_LOAD, 3, 4);
		drain_frame(1);
		calm = 0;
		drain_wait();
	endtask

	// Well-formed frames with random content and lengths, plus broken and noisy ones.
	task automatic test_random_frames();
		int len, shl, shr, nd;
		while (n_sent < 800) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			write_length(len);
			repeat ($urandom_range(2, 6)) begin
				calm = ($urandom_range(0, 4) == 0);
				shl  = $urandom_range(0, 23);
				shr  = $urandom_range(0, 23);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 15) == 0) send_item(KIND_DRAIN, 0, 0);
					send_item(KIND_LOAD, pick_sample(shl), pick_sample(shr));
				end
				nd = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : len;
				drain_frame(nd);
				if ($urandom_range(0, 7) == 0) begin
					// pause the sender until every pair is back
					in_valid <= 0;
					@(posedge clk);
					while (pending_pairs.size() != 0) @(posedge clk);
				end
			end
			// finish any cut-short frame so the block is idle before the next length
			if (pl_phase == PH_EMPTY) drain_frame(n_loaded - n_drained);
			else if (n_loaded != 0) begin
				while (pl_phase == PH_FILL) send_item(KIND_LOAD, pick_sample(4), pick_sample(4));
				drain_frame(n_loaded);
			end
			calm = 0;
			drain_wait();
		end
	endtask

	initial begin
		arst_n       = 0;
		cfg_valid    = 0;
		frame_length = 0;
		in_valid     = 0;
		kind         = 0;
		left_sample  = 0;
		right_sample = 0;
		out_ready    = 0;
		out_wait     = 0;
		out_took     = 0;
		failed       = 0;
		calm         = 0;
		n_sent       = 0;
		cycles       = 0;
		nrg_left     = 0;
		nrg_right    = 0;
		n_loaded     = 0;
		n_drained    = 0;
		pl_phase     = PH_FILL;
		pl_level     = 1;
		pl_gain      = GAIN_ONE;
		pl_scale_right = 0;
		pl_len       = FMAX;
		sat_mag      = root64(64'd1 << 47);
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_length_limits();
		test_random_frames();
		drain_wait();
		if (!failed) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end

endmodule
